@@ rtl/clfd_pkg.sv @@
`default_nettype none
package clfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 32;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned ROLE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [ROLE_W-1:0] ROLE_NAME = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_BODY = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_END  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LEN_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_TERM  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 1'd1;

    localparam logic [LEN_W-1:0]  MIN_FRAME_LEN   = 32'd7;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 32'd67108864;
    localparam logic [BYTE_W-1:0] NAME_END_BYTE   = 8'd0;
    localparam logic [CRC_W-1:0]  CRC_POLY_REFL   = 16'hA001;

    typedef struct packed {
        logic [ROLE_W-1:0]   role;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] frame_status;
        logic                last;
    } t_result;

    // CRC-16/ARC, reflected, one byte
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/clfd_byte_if.sv @@
`default_nettype none
interface clfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/clfd_res_if.sv @@
`default_nettype none
interface clfd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] role;
    logic [7:0] data_byte;
    logic [1:0] frame_status;
    logic       last;

    modport source (output valid, output role, output data_byte, output frame_status,
                    output last, input ready);
    modport sink   (input valid, input role, input data_byte, input frame_status,
                    input last, output ready);
endinterface
`default_nettype wire

@@ rtl/clfd_parse.sv @@
`default_nettype none
module clfd_parse (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire  [clfd_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                         o_in_ready,
    input  wire                          i_full,
    input  wire                          i_cfg_we,
    input  wire  [clfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [clfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                         o_push,
    output clfd_pkg::t_result            o_res
);
    import clfd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_BODY,
        PH_CHECK,
        PH_CHECK_NOTERM,
        PH_HALTED
    } t_phase;

    t_phase            r_phase, n_phase, w_after;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  w_len_full;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_cklo, n_cklo;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_verify_en;
    logic [LEN_W-1:0]  r_max_len;
    logic              w_go;
    logic              w_fin;
    logic [STATUS_W-1:0] w_status;

    assign w_go       = r_in_valid && !i_full;
    assign o_in_ready = !r_in_valid || !i_full;
    assign w_len_full = r_len | ({{(LEN_W-BYTE_W){1'b0}}, r_in_byte} << {r_idx[1:0], 3'b000});

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_len    = r_len;
        n_crc    = r_crc;
        n_cklo   = r_cklo;
        w_after  = r_phase;
        w_fin    = 1'b0;
        w_status = ST_OK;
        o_push   = 1'b0;
        o_res    = '0;
        if (w_go) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_crc = crc_update(r_crc, r_in_byte);
                    n_len = w_len_full;
                    n_idx = r_idx + 1'b1;
                    if (r_idx[1:0] == 2'd3) begin
                        if (w_len_full > r_max_len || w_len_full < MIN_FRAME_LEN) begin
                            w_fin    = 1'b1;
                            w_status = ST_LEN_ERR;
                        end else begin
                            n_phase = PH_NAME;
                            n_len   = w_len_full - 32'd2;
                        end
                    end
                end
                PH_NAME, PH_BODY: begin
                    n_crc = crc_update(r_crc, r_in_byte);
                    n_idx = r_idx + 1'b1;
                    if (r_phase == PH_BODY) begin
                        o_push          = 1'b1;
                        o_res.role      = ROLE_BODY;
                        o_res.data_byte = r_in_byte;
                    end else if (r_in_byte == NAME_END_BYTE) begin
                        w_after = PH_BODY;
                    end else begin
                        o_push          = 1'b1;
                        o_res.role      = ROLE_NAME;
                        o_res.data_byte = r_in_byte;
                    end
                    n_phase = w_after;
                    if (n_idx == r_len) begin
                        n_phase = (w_after == PH_NAME) ? PH_CHECK_NOTERM : PH_CHECK;
                    end
                end
                PH_CHECK, PH_CHECK_NOTERM: begin
                    if (r_idx == r_len) begin
                        n_cklo = r_in_byte;
                        n_idx  = r_idx + 1'b1;
                    end else begin
                        w_fin = 1'b1;
                        if (r_verify_en && {r_in_byte, r_cklo} != r_crc) begin
                            w_status = ST_CRC_ERR;
                        end else if (r_phase == PH_CHECK_NOTERM) begin
                            w_status = ST_NO_TERM;
                        end else begin
                            w_status = ST_OK;
                        end
                    end
                end
                PH_HALTED: begin
                end
                default: begin
                end
            endcase
            if (w_fin) begin
                o_push             = 1'b1;
                o_res.role         = ROLE_END;
                o_res.data_byte    = '0;
                o_res.frame_status = w_status;
                o_res.last         = 1'b1;
                n_phase = (w_status != ST_OK) ? PH_HALTED : PH_HEADER;
                n_idx   = '0;
                n_len   = '0;
                n_crc   = '0;
                n_cklo  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_idx       <= '0;
            r_len       <= '0;
            r_crc       <= '0;
            r_cklo      <= '0;
            r_in_valid  <= 1'b0;
            r_verify_en <= 1'b1;
            r_max_len   <= MAX_LEN_RESET;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_cklo  <= n_cklo;
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VERIFY_EN: r_verify_en <= i_cfg_data[0];
                    CFG_MAX_LEN:   r_max_len   <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALTED |-> !o_push)
        else $error("result pushed while halted");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.last && o_res.frame_status != ST_OK) |=> r_phase == PH_HALTED)
        else $error("error status did not halt parser");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_full |-> !o_push)
        else $error("push into full result queue");

endmodule
`default_nettype wire

@@ rtl/clfd_outq.sv @@
`default_nettype none
module clfd_outq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire clfd_pkg::t_result i_res,
    output logic               o_full,
    clfd_res_if.source         o_out
);
    import clfd_pkg::*;

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_pop;
    t_result    w_head;

    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;
    assign o_full = (r_cnt == 2'd2);
    assign w_head = r_mem[r_rp];

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.role         = w_head.role;
    assign o_out.data_byte    = w_head.data_byte;
    assign o_out.frame_status = w_head.frame_status;
    assign o_out.last         = w_head.last;

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count overflow");

endmodule
`default_nettype wire

@@ rtl/crc16_length_frame_deframer.sv @@
// Deframer for length-prefixed frames: 32-bit LE length, zero-terminated
// type name, body, 16-bit LE CRC-16/ARC over everything before it.
// Input channel i_in carries one stream byte per beat; output channel o_out
// carries one result per beat: a name byte, a body byte, or a frame-end
// beat (last = 1) with the frame status.
// Path: a byte accepted on i_in is registered, parsed while the two-entry
// result queue is not full, and any result it gives shows on o_out from the queue.
// Throughput: one byte per cycle while the queue has room; the parser holds
// one byte and the CRC is updated a byte per cycle in the parse stage.
// Config: i_cfg_we/i_cfg_index/i_cfg_data write verify enable (index 0) and
// max frame length (index 1); write only while idle.
// Reset (synchronous, active low) clears the parser to expect a header,
// empties the queue and restores the register defaults. Any error status
// halts the parser until reset; bytes are still taken and dropped.
// When the receiver stalls, the queue fills, the held byte waits and i_in
// ready drops; no beat is lost.
`default_nettype none
module crc16_length_frame_deframer (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    clfd_byte_if.sink                        i_in,
    clfd_res_if.source                       o_out,
    input  wire                              i_cfg_we,
    input  wire  [clfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [clfd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import clfd_pkg::*;

    logic    w_in_ready;
    logic    w_full;
    logic    w_push;
    t_result w_res;

    assign i_in.ready = w_in_ready;

    clfd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_byte   (i_in.stream_byte),
        .o_in_ready  (w_in_ready),
        .i_full      (w_full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_res       (w_res)
    );

    clfd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
    import clfd_pkg::*;

    typedef logic [7:0] t_bytes[$];
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle_mode;
    typedef enum logic [2:0] {
        PH_HDR, PH_NAME, PH_BODY, PH_CHK, PH_CHK_NOTERM, PH_HALT
    } t_parse_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    clfd_byte_if byte_if();
    clfd_res_if  res_if();

    crc16_length_frame_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (byte_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state and register copies
    t_parse_phase  prs_phase;
    logic [31:0]   prs_idx;
    logic [31:0]   prs_len;
    logic [15:0]   prs_crc;
    logic [7:0]    prs_chk_lo;
    logic          cfg_verify;
    logic [31:0]   cfg_max_len;

    t_result       expected_results[$];
    t_idle_mode    mode;
    int unsigned   fail_count = 0;
    int unsigned   bytes_accepted;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] arc_crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = {1'b0, c[15:1]} ^ (fb ? 16'hA001 : 16'h0000);
        end
        return c;
    endfunction

    function automatic int unsigned idle_pct(input t_idle_mode m, input bit sink_side);
        case (m)
            IDLE_SRC:  return sink_side ? 0 : 52;
            IDLE_SNK:  return sink_side ? 52 : 0;
            IDLE_BOTH: return 8;
            default:   return 0;
        endcase
    endfunction

    function automatic t_bytes rand_bytes(input int unsigned n, input bit nonzero);
        t_bytes q;
        logic [7:0] v;
        for (int unsigned k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0:       v = nonzero ? 8'h01 : 8'h00;
                1:       v = 8'hFF;
                default: v = nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255));
            endcase
            q = {q, v};
        end
        return q;
    endfunction

    task automatic expect_beat(input t_result r);
        expected_results = {expected_results, r};
    endtask

    task automatic end_frame(input logic [STATUS_W-1:0] status);
        expect_beat('{ROLE_END, 8'h00, status, 1'b1});
        prs_phase  = (status != ST_OK) ? PH_HALT : PH_HDR;
        prs_idx    = '0;
        prs_len    = '0;
        prs_crc    = '0;
        prs_chk_lo = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        case (prs_phase)
            PH_HDR: begin
                prs_crc = arc_crc_byte(prs_crc, b);
                prs_len[8*prs_idx[1:0] +: 8] = b;
                prs_idx = prs_idx + 1;
                if (prs_idx == 32'd4) begin
                    if (prs_len > cfg_max_len || prs_len < MIN_FRAME_LEN) begin
                        end_frame(ST_LEN_ERR);
                    end else begin
                        prs_phase = PH_NAME;
                    end
                end
            end
            PH_NAME, PH_BODY: begin
                prs_crc = arc_crc_byte(prs_crc, b);
                prs_idx = prs_idx + 1;
                if (prs_phase == PH_BODY) begin
                    expect_beat('{ROLE_BODY, b, ST_OK, 1'b0});
                end else if (b == NAME_END_BYTE) begin
                    prs_phase = PH_BODY;
                end else begin
                    expect_beat('{ROLE_NAME, b, ST_OK, 1'b0});
                end
                if (prs_idx == prs_len - 32'd2) begin
                    prs_phase = (prs_phase == PH_NAME) ? PH_CHK_NOTERM : PH_CHK;
                end
            end
            PH_CHK, PH_CHK_NOTERM: begin
                if (prs_idx == prs_len - 32'd2) begin
                    prs_chk_lo = b;
                    prs_idx    = prs_idx + 1;
                end else if (cfg_verify && {b, prs_chk_lo} != prs_crc) begin
                    end_frame(ST_CRC_ERR);
                end else if (prs_phase == PH_CHK_NOTERM) begin
                    end_frame(ST_NO_TERM);
                end else begin
                    end_frame(ST_OK);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct(mode, 1'b0)) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.stream_byte <= b;
        do @(posedge i_clk); while (!byte_if.ready);
        parse_byte(b);
        bytes_accepted++;
    endtask

    task automatic send_frame(input t_bytes name, input t_bytes body, input bit with_term,
                              input logic [15:0] crc_flip);
        t_bytes      frame;
        logic [31:0] flen;
        logic [15:0] crc;
        flen = 32'(name.size() + body.size() + 6 + with_term);
        for (int k = 0; k < 4; k++) frame = {frame, flen[8*k +: 8]};
        foreach (name[k]) frame = {frame, name[k]};
        if (with_term) frame = {frame, NAME_END_BYTE};
        foreach (body[k]) frame = {frame, body[k]};
        crc = '0;
        foreach (frame[k]) crc = arc_crc_byte(crc, frame[k]);
        crc = crc ^ crc_flip;
        frame = {frame, crc[7:0]};
        frame = {frame, crc[15:8]};
        foreach (frame[k]) send_byte(frame[k]);
    endtask

    task automatic send_header(input logic [31:0] flen);
        for (int k = 0; k < 4; k++) send_byte(flen[8*k +: 8]);
    endtask

    // header bytes and terminators give no result: allow pipeline to settle too
    task automatic drain_results();
        byte_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        if (idx == CFG_VERIFY_EN) cfg_verify = value[0];
        else if (idx == CFG_MAX_LEN) cfg_max_len = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_frame();
        int unsigned room;
        int unsigned n;
        int unsigned b;
        logic [15:0] flip;
        room = ((cfg_max_len > 32'd30) ? 30 : int'(cfg_max_len)) - 7;
        n    = $urandom_range(0, (room < 4) ? room : 4);
        b    = $urandom_range(0, (room - n < 14) ? room - n : 14);
        flip = '0;
        if (!cfg_verify && $urandom_range(0, 3) == 0) flip = 16'($urandom_range(1, 65535));
        send_frame(rand_bytes(n, 1'b1), rand_bytes(b, 1'b0), 1'b1, flip);
    endtask

    task automatic test_reset_config();
        t_bytes nm;
        t_bytes bd;
        nm = '{8'hFF, 8'h01};
        bd = '{8'h00, 8'hFF, 8'h80};
        send_frame(nm, bd, 1'b1, 16'h0000);
    endtask

    task automatic test_min_length();
        t_bytes none;
        t_bytes nm;
        nm = '{8'h41};
        drain_results();
        write_reg(CFG_MAX_LEN, MIN_FRAME_LEN);
        send_frame(none, none, 1'b1, 16'h0000);
        drain_results();
        write_reg(CFG_MAX_LEN, 32'hFFFF_FFFF);
        send_frame(nm, none, 1'b1, 16'h0000);
    endtask

    task automatic test_crc_bypass();
        t_bytes none;
        t_bytes bd;
        bd = '{8'h7E};
        drain_results();
        write_reg(CFG_VERIFY_EN, 32'd0);
        send_frame(none, bd, 1'b1, 16'hFFFF);
        drain_results();
        write_reg(CFG_VERIFY_EN, 32'd1);
    endtask

    task automatic test_random_frames();
        int unsigned start;
        bit          paused;
        logic [31:0] max_len;
        for (int p = 0; p < 4; p++) begin
            drain_results();
            write_reg(CFG_VERIFY_EN, 32'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0:       max_len = MIN_FRAME_LEN;
                1:       max_len = 32'hFFFF_FFFF;
                2:       max_len = MAX_LEN_RESET;
                default: max_len = 32'($urandom_range(7, 30));
            endcase
            write_reg(CFG_MAX_LEN, max_len);
            mode   = t_idle_mode'(p);
            start  = bytes_accepted;
            paused = 1'b0;
            while (bytes_accepted - start < 130) begin
                send_random_frame();
                if (mode == IDLE_SRC && !paused && bytes_accepted - start >= 65) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // only one error per run: the parser stays halted until reset
    task automatic test_error_halt();
        t_bytes      none;
        logic [31:0] max_len;
        int unsigned kind;
        kind = $urandom_range(0, 3);
        drain_results();
        mode = IDLE_BOTH;
        write_reg(CFG_MAX_LEN, 32'hFFFF_FFFF);
        case (kind)
            0: send_header(32'($urandom_range(0, 6)));
            1: begin
                max_len = 32'($urandom_range(7, 1000));
                write_reg(CFG_MAX_LEN, max_len);
                send_header(32'($urandom_range(32'hFFFF_FFFF, max_len + 1)));
            end
            2: begin
                write_reg(CFG_VERIFY_EN, 32'd1);
                send_frame(rand_bytes($urandom_range(0, 3), 1'b1),
                           rand_bytes($urandom_range(0, 6), 1'b0), 1'b1,
                           16'($urandom_range(1, 65535)));
            end
            default: begin
                write_reg(CFG_VERIFY_EN, 32'($urandom_range(0, 1)));
                send_frame(rand_bytes($urandom_range(1, 5), 1'b1), none, 1'b0, 16'h0000);
            end
        endcase
        // bytes after the error must be dropped
        repeat (16) send_byte(8'($urandom_range(0, 255)));
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.role, res_if.data_byte, res_if.frame_status, res_if.last};
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: role %0d data %0h status %0d last %0d",
                       got.role, got.data_byte, got.frame_status, got.last);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.role !== want.role) begin
                    $error("role: expected %0d, got %0d", want.role, got.role);
                    fail_count++;
                end
                if (got.data_byte !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                    fail_count++;
                end
                if (got.frame_status !== want.frame_status) begin
                    $error("frame_status: expected %0d, got %0d",
                           want.frame_status, got.frame_status);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
        res_if.ready <= ($urandom_range(0, 99) >= idle_pct(mode, 1'b1));
    end

    initial begin
        byte_if.valid       <= 1'b0;
        byte_if.stream_byte <= '0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= '0;
        i_cfg_data          <= '0;
        i_rst_n             <= 1'b0;
        prs_phase      = PH_HDR;
        prs_idx        = '0;
        prs_len        = '0;
        prs_crc        = '0;
        prs_chk_lo     = '0;
        cfg_verify     = 1'b1;
        cfg_max_len    = MAX_LEN_RESET;
        mode           = IDLE_NONE;
        bytes_accepted = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_min_length();
        test_crc_bypass();
        test_random_frames();
        test_error_halt();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
